// File: rtl/bkt_pkg.sv
// ----------------------------------------------------------------------------
// bkt_pkg
// Shared types and constants for the bug keyer timing block.
// ----------------------------------------------------------------------------
package bkt_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned REG_W     = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] FLUSH_TWITCHES = COUNT_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TWITCH_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOT_MS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PTT_MS    = 2'd2;

  localparam logic [REG_W-1:0] TWITCH_MS_RST = REG_W'(10);
  localparam logic [REG_W-1:0] DOT_MS_RST    = REG_W'(60);
  localparam logic [REG_W-1:0] PTT_MS_RST    = REG_W'(0);

  // transmitter commands
  localparam logic [CODE_W-1:0] TX_NONE = 2'd0;
  localparam logic [CODE_W-1:0] TX_DOWN = 2'd1;
  localparam logic [CODE_W-1:0] TX_UP   = 2'd2;

  // report kinds
  localparam logic [CODE_W-1:0] REP_NONE     = 2'd0;
  localparam logic [CODE_W-1:0] REP_UP_END   = 2'd1;
  localparam logic [CODE_W-1:0] REP_DOWN_END = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_CMP  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DEC  = 5'b10000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/bkt_div.sv
// ----------------------------------------------------------------------------
// bkt_div
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit.
// ----------------------------------------------------------------------------
module bkt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bkt_pkg::TIME_W-1:0]  dividend,
  input  logic [bkt_pkg::REG_W-1:0]   divisor,
  output bkt_pkg::div_stat_t          stat,
  output logic [bkt_pkg::TIME_W-1:0]  quotient,
  output logic [bkt_pkg::REG_W-1:0]   remainder
);

  logic                          busy;
  logic                          done;
  logic [bkt_pkg::DIV_CNT_W-1:0] cnt;
  logic [bkt_pkg::REG_W-1:0]     rem;
  logic [bkt_pkg::TIME_W-1:0]    quo;

  logic [bkt_pkg::REG_W:0]       partial;
  logic [bkt_pkg::REG_W+1:0]     diff;
  logic                          ge;
  logic [bkt_pkg::REG_W-1:0]     rem_next;

  always_comb begin
    partial  = {rem, quo[bkt_pkg::TIME_W-1]};
    diff     = {1'b0, partial} - {2'b00, divisor};
    ge       = ~diff[bkt_pkg::REG_W+1];
    rem_next = ge ? diff[bkt_pkg::REG_W-1:0] : partial[bkt_pkg::REG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == bkt_pkg::DIV_CNT_W'(bkt_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[bkt_pkg::TIME_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: rtl/bug_keyer_timing.sv
// ----------------------------------------------------------------------------
// bug_keyer_timing
// Semi-automatic bug key emulation with twitch-unit interval reports.
// ----------------------------------------------------------------------------
// Input stream s_*: one sample per transfer (timestamp, contact levels,
// paddle mode). Output stream m_*: exactly one result per sample, in order.
// Configuration channel cfg_*: register index and 16-bit data, always ready;
// write it only while no sample is in flight.
// One sample is worked on at a time. An accepted sample goes through the
// accumulate, compare and decision steps to the output register; when the
// accumulated time is split into twitches, a divide step comes between them,
// in which the 32-step restoring divider takes one quotient bit per cycle.
// s_tready is high again in the cycle the result appears, so the next sample
// is taken only after the last one is through.
// The output register holds its result until m_tready; while it is full the
// block finishes the next sample up to the decision step and then waits.
// Reset (rst, synchronous) clears all timing state, restores the register
// defaults (twitch 10 ms, dot 60 ms, ptt delay 0 ms) and empties the output.
// ----------------------------------------------------------------------------
module bug_keyer_timing (
  input  logic                            clk,
  input  logic                            rst,
  // cfg write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bkt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bkt_pkg::REG_W-1:0]       cfg_data,
  // samples
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [39:0]                     s_tdata,  // now_ms, dit_closed, dah_closed,
                                                    // right_closed, left_closed,
                                                    // paddle_mode, zero fill
  // results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,  // tx_action, report_twitches,
                                                    // right_edge, left_edge, zero fill
  output logic [bkt_pkg::CODE_W-1:0]      m_tuser   // report_kind
);

  localparam int unsigned TW = bkt_pkg::TIME_W;
  localparam int unsigned CW = bkt_pkg::COUNT_W;

  bkt_pkg::state_t state;

  logic [bkt_pkg::REG_W-1:0] twitch_ms;
  logic [bkt_pkg::REG_W-1:0] dot_ms;
  logic [bkt_pkg::REG_W-1:0] ptt_delay_ms;
  logic [bkt_pkg::REG_W-1:0] tlen;

  logic [TW-1:0] twitch_accum_ms;
  logic [TW-1:0] last_time_ms;
  logic [CW-1:0] twitch_count;
  logic          straight_keyed;
  logic          dit_on;
  logic [TW-1:0] next_transition_ms;
  logic          right_prev;
  logic          left_prev;

  // latched sample
  logic [TW-1:0] now_ms;
  logic          dit_closed;
  logic          dah_closed;
  logic          paddle_mode;
  logic          right_edge;
  logic          left_edge;

  // output register
  logic                      out_valid;
  logic [bkt_pkg::CODE_W-1:0] out_tx;
  logic [bkt_pkg::CODE_W-1:0] out_kind;
  logic [CW-1:0]             out_rep;
  logic                      out_redge;
  logic                      out_ledge;

  // divider
  logic                      div_start;
  bkt_pkg::div_stat_t        div_stat;
  logic [TW-1:0]             div_quo;
  logic [bkt_pkg::REG_W-1:0] div_rem;
  logic [CW:0]               count_sum;
  logic                      count_sat;

  // decision
  logic                       out_free;
  logic [bkt_pkg::CODE_W-1:0] tx_next;
  logic [bkt_pkg::CODE_W-1:0] kind_next;
  logic [CW-1:0]              rep_next;
  logic                       straight_keyed_next;
  logic                       dit_on_next;
  logic [TW-1:0]              next_transition_next;
  logic [CW-1:0]              count_next;
  logic                       accum_clear;
  logic                       due;

  assign tlen      = (twitch_ms == '0) ? bkt_pkg::REG_W'(1) : twitch_ms;
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == bkt_pkg::S_IDLE);
  assign out_free  = ~out_valid | m_tready;
  assign div_start = (state == bkt_pkg::S_CMP) && (twitch_accum_ms > TW'(tlen));

  bkt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (twitch_accum_ms - TW'(1)),
    .divisor   (tlen),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign count_sum = {1'b0, twitch_count} + {1'b0, div_quo[CW-1:0]};
  assign count_sat = (|div_quo[TW-1:CW]) | count_sum[CW];

  always_comb begin
    tx_next              = bkt_pkg::TX_NONE;
    kind_next            = bkt_pkg::REP_NONE;
    rep_next             = '0;
    straight_keyed_next  = straight_keyed;
    dit_on_next          = dit_on;
    next_transition_next = next_transition_ms;
    count_next           = twitch_count;
    accum_clear          = 1'b0;
    due                  = (next_transition_ms < now_ms);
    if (paddle_mode) begin
      if (dah_closed) begin
        next_transition_next = now_ms;
        dit_on_next          = 1'b0;
        if (!straight_keyed) begin
          straight_keyed_next = 1'b1;
          kind_next           = bkt_pkg::REP_UP_END;
          tx_next             = bkt_pkg::TX_DOWN;
          rep_next            = twitch_count;
          count_next          = '0;
          accum_clear         = 1'b1;
        end
      end else if (dit_closed) begin
        if (due) begin
          if (!dit_on) begin
            dit_on_next          = 1'b1;
            kind_next            = bkt_pkg::REP_UP_END;
            tx_next              = bkt_pkg::TX_DOWN;
            next_transition_next = now_ms + TW'(dot_ms) + TW'(ptt_delay_ms);
          end else begin
            dit_on_next          = 1'b0;
            kind_next            = bkt_pkg::REP_DOWN_END;
            tx_next              = bkt_pkg::TX_UP;
            next_transition_next = now_ms + TW'(dot_ms);
          end
          rep_next    = twitch_count;
          count_next  = '0;
          accum_clear = 1'b1;
        end
      end else if (dit_on) begin
        if (due) begin
          dit_on_next          = 1'b0;
          kind_next            = bkt_pkg::REP_DOWN_END;
          tx_next              = bkt_pkg::TX_UP;
          rep_next             = twitch_count;
          next_transition_next = now_ms + TW'(dot_ms);
          count_next           = '0;
          accum_clear          = 1'b1;
        end
      end else begin
        next_transition_next = now_ms;
        if (straight_keyed) begin
          straight_keyed_next = 1'b0;
          kind_next           = bkt_pkg::REP_DOWN_END;
          tx_next             = bkt_pkg::TX_UP;
          rep_next            = twitch_count;
          count_next          = '0;
          accum_clear         = 1'b1;
        end
      end
    end
    // flush a long interval, accumulator is kept
    if (kind_next == bkt_pkg::REP_NONE && count_next >= bkt_pkg::FLUSH_TWITCHES) begin
      kind_next  = (straight_keyed_next | dit_on_next) ? bkt_pkg::REP_DOWN_END
                                                       : bkt_pkg::REP_UP_END;
      rep_next   = count_next;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= bkt_pkg::S_IDLE;
      twitch_ms          <= bkt_pkg::TWITCH_MS_RST;
      dot_ms             <= bkt_pkg::DOT_MS_RST;
      ptt_delay_ms       <= bkt_pkg::PTT_MS_RST;
      twitch_accum_ms    <= '0;
      last_time_ms       <= '0;
      twitch_count       <= '0;
      straight_keyed     <= 1'b0;
      dit_on             <= 1'b0;
      next_transition_ms <= '0;
      right_prev         <= 1'b0;
      left_prev          <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bkt_pkg::REG_TWITCH_MS: twitch_ms    <= cfg_data;
          bkt_pkg::REG_DOT_MS:    dot_ms       <= cfg_data;
          bkt_pkg::REG_PTT_MS:    ptt_delay_ms <= cfg_data;
          default: ;
        endcase
      end

      // the decision step reloads the output in the same cycle
      if (out_valid && m_tready && state != bkt_pkg::S_DEC) begin
        out_valid <= 1'b0;
      end

      case (state)
        bkt_pkg::S_IDLE: begin
          if (s_tvalid) begin
            right_prev <= s_tdata[34];
            left_prev  <= s_tdata[35];
            state      <= bkt_pkg::S_ACC;
          end
        end
        bkt_pkg::S_ACC: begin
          twitch_accum_ms <= twitch_accum_ms + (now_ms - last_time_ms);
          last_time_ms    <= now_ms;
          state           <= bkt_pkg::S_CMP;
        end
        bkt_pkg::S_CMP: begin
          state <= div_start ? bkt_pkg::S_DIV : bkt_pkg::S_DEC;
        end
        bkt_pkg::S_DIV: begin
          // remainder of (accum - 1) plus one leaves 1..tlen
          if (div_stat.done) begin
            twitch_accum_ms <= TW'(div_rem) + TW'(1);
            twitch_count    <= count_sat ? bkt_pkg::COUNT_MAX : count_sum[CW-1:0];
            state           <= bkt_pkg::S_DEC;
          end
        end
        bkt_pkg::S_DEC: begin
          if (out_free) begin
            straight_keyed     <= straight_keyed_next;
            dit_on             <= dit_on_next;
            next_transition_ms <= next_transition_next;
            twitch_count       <= count_next;
            if (accum_clear) begin
              twitch_accum_ms <= '0;
            end
            out_valid <= 1'b1;
            state     <= bkt_pkg::S_IDLE;
          end
        end
        default: state <= bkt_pkg::S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == bkt_pkg::S_IDLE && s_tvalid) begin
      now_ms      <= s_tdata[31:0];
      dit_closed  <= s_tdata[32];
      dah_closed  <= s_tdata[33];
      paddle_mode <= s_tdata[36];
      right_edge  <= s_tdata[34] & ~right_prev;
      left_edge   <= s_tdata[35] & ~left_prev;
    end
    if (state == bkt_pkg::S_DEC && out_free) begin
      out_tx    <= tx_next;
      out_kind  <= kind_next;
      out_rep   <= rep_next;
      out_redge <= right_edge;
      out_ledge <= left_edge;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_ledge, out_redge, out_rep, out_tx};
  assign m_tuser  = out_kind;

  // the divider only runs while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == bkt_pkg::S_DIV))
    else $error("divider busy outside the divide step");

  // any count of a full flush is reported before the next sample is taken
  a_count_flushed: assert property (@(posedge clk) disable iff (rst)
    (state == bkt_pkg::S_IDLE) |-> (twitch_count < bkt_pkg::FLUSH_TWITCHES))
    else $error("twitch count left at or above flush level");

  // a key-down command always closes a key-up interval
  a_down_reports_up: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == bkt_pkg::TX_DOWN) |-> (m_tuser == bkt_pkg::REP_UP_END))
    else $error("key down without key-up report");

  // no report means no length
  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == bkt_pkg::REP_NONE) |-> (m_tdata[17:2] == '0))
    else $error("report length set without a report");

endmodule
